// File: rtl/core/hashed_timer_wheel_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef HASHED_TIMER_WHEEL_UNIT_DEFINES_SVH
`define HASHED_TIMER_WHEEL_UNIT_DEFINES_SVH

// Assert an implication that holds in the next cycle.
`define HTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Assert an implication within the same cycle.
`define HTW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/htw_pkg.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel package
// Shared types and operation codes for the timer wheel block.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam logic [23:0] LEFT_MAX   = 24'hFFFFFF;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_REG_LOOP  = 3'd1,
        OP_REG_LIMIT = 3'd2,
        OP_REG_DELAY = 3'd3,
        OP_UNREG     = 3'd4,
        OP_QUERY     = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  timer_id;
        logic [23:0] interval;
        logic [15:0] repeat_count;
    } t_req;

    typedef struct packed {
        logic [3:0]  result_id;
        logic        fired;
        logic [23:0] left_time;
        logic        status;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_QMUL,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture request
        logic cmd_exec;  // perform single-entry command and emit result
        logic qmul;      // register query product
        logic q_emit;    // emit query result
        logic scan_step; // visit one entry of the tick scan
        logic scan_init; // advance slot, clear scan index
    } t_ctl;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick;
        logic is_query;
        logic scan_end;
    } t_sts;

endpackage

// File: rtl/core/htw_datapath.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel datapath
// Timer table, slot counter, scan index and result register.
// ----------------------------------------------------------------------------
module htw_datapath #(
    parameter int unsigned TIMER_COUNT = 16,
    parameter int unsigned SLOT_COUNT  = 64,
    parameter int unsigned SLOT_TIME   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  htw_pkg::t_req  i_req,
    input  htw_pkg::t_ctl  i_ctl,
    output htw_pkg::t_sts  o_sts,
    output logic           o_strobe,
    output htw_pkg::t_res  o_res
);
    localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int unsigned CW = $clog2(TIMER_COUNT + 1);
    localparam int unsigned TW = 24;

    // Table storage; valid bits reset, payload does not.
    logic [TIMER_COUNT-1:0] r_valid;
    logic [TIMER_COUNT-1:0] r_loop;
    logic [23:0]            r_intv [TIMER_COUNT];
    logic [15:0]            r_cnt  [TIMER_COUNT];
    logic [SW-1:0]          r_slot [TIMER_COUNT];
    logic [TW-1:0]          r_rot  [TIMER_COUNT];

    logic [SW-1:0] r_cur;
    htw_pkg::t_req r_req;
    logic [CW-1:0] r_idx;
    logic [47:0]   r_prod;
    logic [SW-1:0] r_diff;
    logic          r_strobe;
    logic          n_strobe;
    htw_pkg::t_res r_res;
    htw_pkg::t_res n_res;
    logic          r_pend;
    logic [IW-1:0] r_pend_id;

    logic          in_tab;
    logic [IW-1:0] id;
    logic [IW-1:0] si;
    logic [TW-1:0] ticks;
    logic [TW-1:0] cmd_rot;
    logic [SW-1:0] cmd_slot;
    logic [TW-1:0] sc_rot;
    logic [SW-1:0] sc_slot;
    logic          due;
    logic [15:0]   cnt_dec;
    logic [48:0]   left_sum;

    assign id     = r_req.timer_id[IW-1:0];
    assign in_tab = ({28'd0, r_req.timer_id} < 32'(TIMER_COUNT));
    assign si     = r_idx[IW-1:0];

    // Schedule from the requested or stored interval; divisions are by constants.
    function automatic logic [TW-1:0] f_ticks(input logic [23:0] iv);
        f_ticks = TW'(iv / SLOT_TIME);
    endfunction

    assign ticks    = f_ticks(r_req.interval);
    assign cmd_rot  = TW'(ticks / SLOT_COUNT);
    assign cmd_slot = SW'((32'(ticks % SLOT_COUNT) + 32'(r_cur)) % SLOT_COUNT);
    assign sc_rot   = TW'(f_ticks(r_intv[si]) / SLOT_COUNT);
    assign sc_slot  = SW'((32'(f_ticks(r_intv[si]) % SLOT_COUNT) + 32'(r_cur)) % SLOT_COUNT);
    assign cnt_dec  = (r_cnt[si] != 16'd0) ? r_cnt[si] - 16'd1 : 16'd0;
    assign due      = r_valid[si] && (r_slot[si] == r_cur) && (r_rot[si] == '0);
    assign left_sum = {1'b0, r_prod} + 49'(32'(r_diff) * SLOT_TIME);

    assign o_sts.is_tick  = (r_req.operation == htw_pkg::OP_TICK);
    assign o_sts.is_query = (r_req.operation == htw_pkg::OP_QUERY);
    assign o_sts.scan_end = (r_idx == CW'(TIMER_COUNT));

    // Next result and strobe. During the scan, fired ids are held in a pending
    // register so that the final one can carry last.
    always_comb begin
        n_strobe = 1'b0;
        n_res    = r_res;
        if (i_ctl.cmd_exec) begin
            n_strobe        = 1'b1;
            n_res           = '0;
            n_res.result_id = r_req.timer_id;
            n_res.last      = 1'b1;
            case (r_req.operation)
                htw_pkg::OP_REG_LOOP:
                    n_res.status = !in_tab;
                htw_pkg::OP_REG_LIMIT, htw_pkg::OP_REG_DELAY:
                    n_res.status = !in_tab || (r_req.operation == htw_pkg::OP_REG_DELAY
                                               && r_valid[id]);
                htw_pkg::OP_UNREG:
                    n_res.status = !(in_tab && r_valid[id]);
                default:
                    n_res.status = 1'b1;
            endcase
        end
        if (i_ctl.q_emit) begin
            n_strobe        = 1'b1;
            n_res           = '0;
            n_res.result_id = r_req.timer_id;
            n_res.last      = 1'b1;
            if (!(in_tab && r_valid[id])) begin
                n_res.status = 1'b1;
            end else begin
                n_res.left_time = (left_sum > 49'(htw_pkg::LEFT_MAX))
                                  ? htw_pkg::LEFT_MAX : left_sum[23:0];
            end
        end
        if (i_ctl.scan_step) begin
            if (o_sts.scan_end) begin
                n_strobe        = r_pend;
                n_res           = '0;
                n_res.result_id = 4'(r_pend_id);
                n_res.fired     = 1'b1;
                n_res.last      = 1'b1;
            end else if (due && r_pend) begin
                n_strobe        = 1'b1;
                n_res           = '0;
                n_res.result_id = 4'(r_pend_id);
                n_res.fired     = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cur    <= '0;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_strobe <= n_strobe;
            if (i_ctl.scan_init) begin
                r_cur  <= (r_cur == SW'(SLOT_COUNT - 1)) ? '0 : r_cur + SW'(1);
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            if (i_ctl.cmd_exec) begin
                if (in_tab) begin
                    case (r_req.operation)
                        htw_pkg::OP_REG_LOOP, htw_pkg::OP_REG_LIMIT:
                            r_valid[id] <= 1'b1;
                        htw_pkg::OP_REG_DELAY:
                            r_valid[id] <= 1'b1;
                        htw_pkg::OP_UNREG:
                            r_valid[id] <= 1'b0;
                        default: ;
                    endcase
                end
            end
            // Scan: remember the latest fired id and retire spent timers.
            if (i_ctl.scan_step) begin
                if (o_sts.scan_end) begin
                    r_pend <= 1'b0;
                end else begin
                    r_idx <= r_idx + CW'(1);
                    if (due) begin
                        r_pend    <= 1'b1;
                        r_pend_id <= si;
                        if (!r_loop[si] && cnt_dec == 16'd0) r_valid[si] <= 1'b0;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_req <= i_req;
        if (i_ctl.qmul) begin
            r_prod <= 48'(r_rot[id]) * 48'(SLOT_COUNT * SLOT_TIME);
            r_diff <= SW'((32'(r_slot[id]) + SLOT_COUNT - 32'(r_cur)) % SLOT_COUNT);
        end
        r_res <= n_res;
        if (i_ctl.cmd_exec && in_tab) begin
            case (r_req.operation)
                htw_pkg::OP_REG_LOOP: begin
                    r_loop[id] <= 1'b1;
                    r_intv[id] <= r_req.interval;
                    r_cnt[id]  <= '0;
                    r_rot[id]  <= '0;
                    r_slot[id] <= (r_cur == SW'(SLOT_COUNT - 1)) ? '0 : r_cur + SW'(1);
                end
                htw_pkg::OP_REG_LIMIT, htw_pkg::OP_REG_DELAY: begin
                    if (!(r_req.operation == htw_pkg::OP_REG_DELAY && r_valid[id])) begin
                        r_loop[id] <= 1'b0;
                        r_intv[id] <= r_req.interval;
                        r_cnt[id]  <= (r_req.operation == htw_pkg::OP_REG_DELAY ||
                                       r_req.repeat_count == 16'd0) ? 16'd1
                                      : r_req.repeat_count;
                        r_rot[id]  <= cmd_rot;
                        r_slot[id] <= cmd_slot;
                    end
                end
                default: ;
            endcase
        end
        // Visit one entry: count down its rotation, or on firing reschedule it if it repeats.
        if (i_ctl.scan_step && !o_sts.scan_end) begin
            if (r_valid[si] && r_slot[si] == r_cur) begin
                if (r_rot[si] != '0) begin
                    r_rot[si] <= r_rot[si] - TW'(1);
                end else if (r_loop[si]) begin
                    r_rot[si]  <= sc_rot;
                    r_slot[si] <= sc_slot;
                end else begin
                    r_cnt[si] <= cnt_dec;
                    if (cnt_dec != 16'd0) begin
                        r_rot[si]  <= sc_rot;
                        r_slot[si] <= sc_slot;
                    end
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;
endmodule

// File: rtl/core/htw_ctrl.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel controller
// Sequences command execution, query arithmetic and the tick scan.
// ----------------------------------------------------------------------------
module htw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  htw_pkg::t_sts  i_sts,
    output logic           o_busy,
    output htw_pkg::t_ctl  o_ctl
);
    htw_pkg::t_state r_state;
    htw_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            htw_pkg::ST_IDLE: if (i_start) n_state = htw_pkg::ST_CMD;
            htw_pkg::ST_CMD: begin
                if (i_sts.is_tick)       n_state = htw_pkg::ST_SCAN;
                else if (i_sts.is_query) n_state = htw_pkg::ST_QMUL;
                else                     n_state = htw_pkg::ST_DONE;
            end
            htw_pkg::ST_QMUL: n_state = htw_pkg::ST_DONE;
            htw_pkg::ST_SCAN: if (i_sts.scan_end) n_state = htw_pkg::ST_DONE;
            htw_pkg::ST_DONE: n_state = htw_pkg::ST_IDLE;
            default: n_state = htw_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ctl  = '0;
        o_busy = (r_state != htw_pkg::ST_IDLE);
        case (r_state)
            htw_pkg::ST_IDLE: o_ctl.load = i_start;
            htw_pkg::ST_CMD: begin
                o_ctl.scan_init = i_sts.is_tick;
                o_ctl.qmul      = i_sts.is_query;
                o_ctl.cmd_exec  = !i_sts.is_tick && !i_sts.is_query;
            end
            htw_pkg::ST_QMUL: o_ctl.q_emit = 1'b1;
            htw_pkg::ST_SCAN: o_ctl.scan_step = 1'b1;
            htw_pkg::ST_DONE: ;
            default: ;
        endcase
    end
endmodule

// File: rtl/core/hashed_timer_wheel_unit.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel unit
// Timer table on a slotted wheel with register, unregister, query and tick.
// ----------------------------------------------------------------------------
// One request at a time. After the accepting edge, busy stays high while the
// controller walks its states: CMD and DONE for a register, unregister or
// unknown request, CMD, QMUL and DONE for a query (QMUL forms the
// remaining-time product) and CMD, SCAN and DONE for a tick, the scan visiting
// one table entry per cycle plus a final step to flush the last fired id. A new
// request can be accepted as soon as busy falls. Each result appears for one
// cycle with o_valid high and cannot be held off; the last result of a request
// has last set, and a tick that fires nothing gives no result.
module hashed_timer_wheel_unit #(
    parameter int unsigned TIMER_COUNT = 16,
    parameter int unsigned SLOT_COUNT  = 64,
    parameter int unsigned SLOT_TIME   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  htw_pkg::t_req  i_req,
    output logic           o_valid,
    output htw_pkg::t_res  o_res
);
    htw_pkg::t_ctl ctl;
    htw_pkg::t_sts sts;

    htw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    htw_datapath #(
        .TIMER_COUNT (TIMER_COUNT),
        .SLOT_COUNT  (SLOT_COUNT),
        .SLOT_TIME   (SLOT_TIME)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_strobe (o_valid),
        .o_res    (o_res)
    );
endmodule

// File: rtl/core/htw_checker.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel checker
// Port-level properties of the timer wheel unit.
// ----------------------------------------------------------------------------
`include "hashed_timer_wheel_unit_defines.svh"

module htw_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input htw_pkg::t_res o_res
);
    // A result only comes from a request in progress or just finished.
    `HTW_ASSERT_SAME(a_res_busy, i_clk, i_rst_n, o_valid, busy || $past(busy),
                     "result while idle")
    // A fired result never reports an error or a time.
    `HTW_ASSERT_SAME(a_fired_clean, i_clk, i_rst_n, o_valid && o_res.fired,
                     !o_res.status && o_res.left_time == 24'd0, "bad fired result")
    // An accepted request raises busy.
    `HTW_ASSERT_NEXT(a_accept, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
endmodule

bind hashed_timer_wheel_unit htw_checker u_htw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

// File: dv/hashed_timer_wheel_unit_tb.sv
// ----------------------------------------------------------------------------
// Hashed timer wheel unit testbench
// Sends register, unregister, query and tick requests with random gaps and
// checks every result against a timer wheel predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hashed_timer_wheel_unit_tb;

    localparam int unsigned TIMERS     = 16;
    localparam int unsigned SLOTS      = 64;
    localparam int unsigned SLOT_UNITS = 16;
    localparam int unsigned WATCHDOG   = 20000;
    localparam logic [2:0]  OP_BAD_LO  = 3'd6;
    localparam logic [2:0]  OP_BAD_HI  = 3'd7;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    htw_pkg::t_req i_req;
    logic          o_valid;
    htw_pkg::t_res o_res;

    // Predicted state of the wheel.
    logic        tm_valid [TIMERS];
    logic        tm_loop  [TIMERS];
    logic [23:0] tm_ivl   [TIMERS];
    logic [15:0] tm_count [TIMERS];
    logic [5:0]  tm_slot  [TIMERS];
    logic [17:0] tm_rot   [TIMERS];
    logic [5:0]  wheel_pos;

    htw_pkg::t_res pending_results[$];
    int   error_count;
    int   request_count;
    int   result_count;
    int   fire_count;
    int   idle_cycles;

    hashed_timer_wheel_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Place a timer on the wheel from its interval.
    task automatic place_timer(input int idx);
        int unsigned ticks;
        begin
            ticks = tm_ivl[idx] / SLOT_UNITS;
            tm_rot[idx]  = 18'(ticks / SLOTS);
            tm_slot[idx] = 6'((ticks % SLOTS + wheel_pos) % SLOTS);
        end
    endtask

    function automatic htw_pkg::t_res make_res(input logic [3:0] id, input logic fired,
                                               input logic [23:0] left, input logic status,
                                               input logic last);
        htw_pkg::t_res r;
        r.result_id = id;
        r.fired     = fired;
        r.left_time = left;
        r.status    = status;
        r.last      = last;
        return r;
    endfunction

    // Append one expected result to the queue.
    task automatic queue_result(input htw_pkg::t_res r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // Update the predicted wheel for one request and queue its results.
    task automatic predict_wheel(input htw_pkg::t_req rq);
        logic        due [TIMERS];
        int          n;
        int          first;
        longint      left;
        int unsigned diff;
        int          id;
        begin
            id = rq.timer_id;
            n = 0;
            first = pending_results.size();
            case (rq.operation)
                htw_pkg::OP_TICK: begin
                    wheel_pos = 6'((wheel_pos + 1) % SLOTS);
                    for (int i = 0; i < TIMERS; i++) begin
                        due[i] = 1'b0;
                        if (tm_valid[i] && tm_slot[i] == wheel_pos) begin
                            if (tm_rot[i] == 0) due[i] = 1'b1;
                            else tm_rot[i] = tm_rot[i] - 18'd1;
                        end
                    end
                    for (int i = 0; i < TIMERS; i++) begin
                        if (due[i]) begin
                            if (tm_loop[i]) begin
                                place_timer(i);
                            end else begin
                                if (tm_count[i] > 0) tm_count[i] = tm_count[i] - 16'd1;
                                if (tm_count[i] == 0) tm_valid[i] = 1'b0;
                                else place_timer(i);
                            end
                            queue_result(make_res(4'(i), 1'b1, '0, 1'b0, 1'b0));
                            n++;
                            fire_count++;
                        end
                    end
                    if (n > 0) pending_results[first + n - 1].last = 1'b1;
                end
                htw_pkg::OP_REG_LOOP, htw_pkg::OP_REG_LIMIT, htw_pkg::OP_REG_DELAY: begin
                    if (rq.operation == htw_pkg::OP_REG_DELAY && tm_valid[id]) begin
                        queue_result(make_res(4'(id), 1'b0, '0, 1'b1, 1'b1));
                    end else begin
                        tm_valid[id] = 1'b1;
                        tm_ivl[id] = rq.interval;
                        if (rq.operation == htw_pkg::OP_REG_LOOP) begin
                            tm_loop[id]  = 1'b1;
                            tm_count[id] = '0;
                            tm_rot[id]   = '0;
                            tm_slot[id]  = 6'((wheel_pos + 1) % SLOTS);
                        end else begin
                            tm_loop[id] = 1'b0;
                            if (rq.operation == htw_pkg::OP_REG_LIMIT)
                                tm_count[id] = (rq.repeat_count == 0) ? 16'd1 : rq.repeat_count;
                            else
                                tm_count[id] = 16'd1;
                            place_timer(id);
                        end
                        queue_result(make_res(4'(id), 1'b0, '0, 1'b0, 1'b1));
                    end
                end
                htw_pkg::OP_UNREG: begin
                    queue_result(make_res(4'(id), 1'b0, '0, !tm_valid[id], 1'b1));
                    tm_valid[id] = 1'b0;
                end
                htw_pkg::OP_QUERY: begin
                    if (!tm_valid[id]) begin
                        queue_result(make_res(4'(id), 1'b0, '0, 1'b1, 1'b1));
                    end else begin
                        diff = (tm_slot[id] + SLOTS - wheel_pos) % SLOTS;
                        left = longint'(tm_rot[id]) * SLOTS * SLOT_UNITS + diff * SLOT_UNITS;
                        if (left > htw_pkg::LEFT_MAX) left = htw_pkg::LEFT_MAX;
                        queue_result(make_res(4'(id), 1'b0, left[23:0], 1'b0, 1'b1));
                    end
                end
                default: begin
                    queue_result(make_res(4'(id), 1'b0, '0, 1'b1, 1'b1));
                end
            endcase
        end
    endtask

    // Random gap before a request: mostly short, now and then long.
    function automatic int pick_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
                                        : int'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    // Send one request and wait until busy falls again. Start stays high across
    // back-to-back requests and is dropped only for a gap.
    task automatic send_request(input logic [2:0] op, input logic [3:0] id,
                                input logic [23:0] ivl, input logic [15:0] rep);
        htw_pkg::t_req rq;
        int            gap;
        begin
            gap = pick_gap();
            if (gap > 0) begin
                start <= 1'b0;
                i_req <= htw_pkg::t_req'(47'({$urandom, $urandom}));
                repeat (gap) @(posedge i_clk);
            end
            rq.operation    = op;
            rq.timer_id     = id;
            rq.interval     = ivl;
            rq.repeat_count = rep;
            start <= 1'b1;
            i_req <= rq;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            predict_wheel(rq);
            request_count++;
        end
    endtask

    // Short interval mostly, so that timers fire within the run.
    function automatic logic [23:0] pick_interval;
        case ($urandom_range(0, 9))
            0:       return 24'hFFFFFF;
            1:       return 24'($urandom);
            2:       return 24'($urandom_range(0, 15));
            default: return 24'($urandom_range(0, 2047));
        endcase
    endfunction

    // Check each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, o_res);
                error_count++;
            end else begin
                if (o_res !== pending_results[0]) begin
                    $display("%0t: mismatch, expected %p actual %p",
                             $time, pending_results[0], o_res);
                    error_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired", $time);
            $display("[hashed_timer_wheel_unit] ERROR");
            $finish;
        end
    end

    task automatic test_extremes;
        begin
            send_request(htw_pkg::OP_QUERY, 4'd0, '0, '0);
            send_request(htw_pkg::OP_UNREG, 4'd15, '0, '0);
            send_request(htw_pkg::OP_TICK, 4'd0, '0, '0);
            send_request(htw_pkg::OP_REG_LOOP, 4'd0, 24'd32, 16'hFFFF);
            send_request(htw_pkg::OP_REG_LIMIT, 4'd15, 24'hFFFFFF, 16'd0);
            send_request(htw_pkg::OP_QUERY, 4'd15, '0, '0);
            send_request(htw_pkg::OP_REG_DELAY, 4'd15, 24'd5, '0);
            send_request(htw_pkg::OP_REG_DELAY, 4'd7, 24'd0, '0);
            send_request(htw_pkg::OP_REG_LIMIT, 4'd3, 24'd16, 16'd3);
            send_request(htw_pkg::OP_REG_LIMIT, 4'd9, 24'd17, 16'hFFFF);
            send_request(OP_BAD_LO, 4'd1, 24'hABCDEF, 16'h1234);
            send_request(OP_BAD_HI, 4'd2, 24'hFFFFFF, 16'hFFFF);
            for (int i = 0; i < 5; i++) send_request(htw_pkg::OP_TICK, 4'(i), '0, '0);
            send_request(htw_pkg::OP_QUERY, 4'd0, '0, '0);
            send_request(htw_pkg::OP_QUERY, 4'd3, '0, '0);
            send_request(htw_pkg::OP_UNREG, 4'd0, '0, '0);
            send_request(htw_pkg::OP_UNREG, 4'd15, '0, '0);
        end
    endtask

    // Many timers in the same slot give multi-result ticks.
    task automatic test_full_slot;
        begin
            for (int i = 0; i < TIMERS; i++)
                send_request(htw_pkg::OP_REG_LOOP, 4'(TIMERS - 1 - i), 24'd16, '0);
            for (int i = 0; i < 6; i++) send_request(htw_pkg::OP_TICK, '0, '0, '0);
            for (int i = 0; i < TIMERS; i++) send_request(htw_pkg::OP_UNREG, 4'(i), '0, '0);
        end
    endtask

    task automatic test_random;
        int w;
        logic [2:0] op;
        begin
            for (int k = 0; k < 351; k++) begin
                w = $urandom_range(0, 99);
                if (w < 40)      op = htw_pkg::OP_TICK;
                else if (w < 50) op = htw_pkg::OP_REG_LOOP;
                else if (w < 65) op = htw_pkg::OP_REG_LIMIT;
                else if (w < 75) op = htw_pkg::OP_REG_DELAY;
                else if (w < 83) op = htw_pkg::OP_UNREG;
                else if (w < 97) op = htw_pkg::OP_QUERY;
                else             op = ($urandom_range(0, 1) == 0) ? OP_BAD_LO : OP_BAD_HI;
                send_request(op, 4'($urandom), pick_interval(),
                             ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, 4)));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        error_count = 0;
        request_count = 0;
        result_count = 0;
        fire_count = 0;
        wheel_pos = '0;
        for (int i = 0; i < TIMERS; i++) begin
            tm_valid[i] = 1'b0;
            tm_loop[i]  = 1'b0;
            tm_ivl[i]   = '0;
            tm_count[i] = '0;
            tm_slot[i]  = '0;
            tm_rot[i]   = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_full_slot();
        test_random();
        start <= 1'b0;

        // Drain, then keep watching for stray results.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TIMERS + 10) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results including %0d timer expiries.",
                 request_count, result_count, fire_count);
        if (error_count == 0) begin
            $display("[hashed_timer_wheel_unit] OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[hashed_timer_wheel_unit] ERROR");
        end
        $finish;
    end

endmodule
